// File: hw/rtl/svpt_pkg.sv
// Package with the word types, widths and sine table builder for the SVPWM timing block.
`timescale 1ns / 1ps
`default_nettype none
package svpt_pkg;

  localparam int ANGLE_BITS       = 16;
  localparam int TIME_BITS        = 16;
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int K_BITS     = $clog2(SINE_TABLE_DEPTH);
  localparam int DWELL_BITS = TIME_BITS + 1;
  localparam int SUM_BITS   = TIME_BITS + 2;
  localparam int PHASE_BITS = TIME_BITS + 3;
  localparam int PROD_BITS  = 16 + TIME_BITS + 1;
  localparam int POS_BITS   = ANGLE_BITS + 3;

  localparam logic [63:0] PI_Q30   = 64'hC90FDAA2;
  localparam logic [63:0] SINE_DIV = 64'(3 * SINE_TABLE_DEPTH);
  localparam logic [63:0] ROUND_HALF = 64'(1) << (29 - TIME_BITS);
  localparam logic [63:0] TAYLOR_DIV [1:7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  localparam logic [SUM_BITS-1:0]   ONE_T  = SUM_BITS'(1) << TIME_BITS;
  localparam logic [TIME_BITS-1:0]  FULL_T = '1;
  localparam logic [PROD_BITS-1:0]  AMP_ROUND = PROD_BITS'(16384);

  typedef logic [TIME_BITS-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  typedef struct packed {
    logic [15:0] angle;
    logic [15:0] amplitude;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]  sector;
    logic [15:0] a_edge;
    logic [15:0] a_width;
    logic [15:0] b_edge;
    logic [15:0] b_width;
    logic [15:0] c_edge;
    logic [15:0] c_width;
    logic        overmodulated;
  } result_word_t;

  typedef struct packed {
    logic [2:0]        sidx;
    logic [K_BITS-1:0] k;
    logic [15:0]       amp;
  } sect_word_t;

  function automatic logic [TIME_BITS-1:0] sine_entry(input int unsigned j);
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] rounded;
    x = (64'(j) * PI_Q30) / SINE_DIV;
    sum = x;
    term = x;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[n];
      if ((n % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    rounded = (sum + ROUND_HALF) >> (30 - TIME_BITS);
    return rounded[TIME_BITS-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int j = 0; j <= SINE_TABLE_DEPTH; j++) begin
      rom[j] = sine_entry(j);
    end
    return rom;
  endfunction

  // Per sector and phase, bit 0 selects T1 and bit 1 selects T2; order A, B, C.
  function automatic logic [5:0] phase_select(input logic [2:0] sidx);
    logic [5:0] sel;
    case (sidx)
      3'd0: sel = {2'd3, 2'd2, 2'd0};
      3'd1: sel = {2'd1, 2'd3, 2'd0};
      3'd2: sel = {2'd0, 2'd3, 2'd2};
      3'd3: sel = {2'd0, 2'd1, 2'd3};
      3'd4: sel = {2'd2, 2'd0, 2'd3};
      3'd5: sel = {2'd3, 2'd0, 2'd1};
      default: sel = 6'd0;
    endcase
    return sel;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/svpt_front.sv
// Front end: takes a command word and classifies it into sector and sine table index.
`timescale 1ns / 1ps
`default_nettype none
module svpt_front
  import svpt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      accept,
  input  wire cmd_word_t cmd,
  output logic           sect_valid,
  output sect_word_t     sect
);

  logic [POS_BITS-1:0]   pos;
  logic [ANGLE_BITS-1:0] ph;

  always_comb begin
    pos = (POS_BITS'(cmd.angle[ANGLE_BITS-1:0]) << 2)
        + (POS_BITS'(cmd.angle[ANGLE_BITS-1:0]) << 1);
    ph  = pos[ANGLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sect_valid <= 1'b0;
    end else begin
      sect_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sect.sidx <= pos[POS_BITS-1:ANGLE_BITS];
      sect.k    <= ph[ANGLE_BITS-1 -: K_BITS];
      sect.amp  <= cmd.amplitude;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/svpt_queue.sv
// Two-entry queue that decouples the classifying front end from the timing back end.
`timescale 1ns / 1ps
`default_nettype none
module svpt_queue
  import svpt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire sect_word_t push_word,
  input  wire logic       pop,
  output logic            not_empty,
  output logic [1:0]      count,
  output sect_word_t      head
);

  sect_word_t entries [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic       do_pop;

  assign not_empty = (count != 2'd0);
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/svpt_back.sv
// Back end: sine lookup, dwell times, zero-vector time and per-phase edge and width.
`timescale 1ns / 1ps
`default_nettype none
module svpt_back
  import svpt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire sect_word_t in_word,
  output logic            done,
  output result_word_t    result
);

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic                  v1, v2, v3;
  logic [TIME_BITS-1:0]  s_t1, s_t2;
  logic [15:0]           amp1;
  logic [2:0]            sidx1, sidx2, sidx3;
  logic [DWELL_BITS-1:0] t1, t2, t1_3, t2_3;
  logic [SUM_BITS-1:0]   sum3;
  logic [TIME_BITS-1:0]  t0;
  logic                  ov3;

  logic [K_BITS:0]       k_mirror;
  logic [PROD_BITS-1:0]  prod1, prod2;
  logic [SUM_BITS-1:0]   sum_c;
  logic [SUM_BITS-1:0]   rest_c;
  logic [5:0]            sel;
  logic [PHASE_BITS-1:0] d [0:2];
  logic [PHASE_BITS-1:0] edge_c [0:2];
  logic [PHASE_BITS-1:0] width_c [0:2];
  logic [TIME_BITS-1:0]  edge_s [0:2];
  logic [TIME_BITS-1:0]  width_s [0:2];

  assign k_mirror = (K_BITS+1)'(SINE_TABLE_DEPTH) - {1'b0, in_word.k};

  always_comb begin
    prod1 = PROD_BITS'(amp1) * PROD_BITS'(s_t1) + AMP_ROUND;
    prod2 = PROD_BITS'(amp1) * PROD_BITS'(s_t2) + AMP_ROUND;
    sum_c = SUM_BITS'(t1) + SUM_BITS'(t2);
    rest_c = ONE_T - sum_c;
  end

  always_comb begin
    sel = phase_select(sidx3);
    for (int i = 0; i < 3; i++) begin
      d[i] = (sel[5 - 2*i - 1] ? PHASE_BITS'(t1_3) : '0)
           + (sel[5 - 2*i]     ? PHASE_BITS'(t2_3) : '0);
      edge_c[i]  = (PHASE_BITS'(t0) + PHASE_BITS'(sum3) - d[i]) >> 1;
      width_c[i] = PHASE_BITS'(t0) + d[i];
      edge_s[i]  = (edge_c[i] > PHASE_BITS'(FULL_T)) ? FULL_T
                                                     : edge_c[i][TIME_BITS-1:0];
      width_s[i] = (width_c[i] > PHASE_BITS'(FULL_T)) ? FULL_T
                                                      : width_c[i][TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    s_t2  <= SINE_ROM[{1'b0, in_word.k}];
    s_t1  <= SINE_ROM[k_mirror];
    amp1  <= in_word.amp;
    sidx1 <= in_word.sidx;

    t1    <= prod1[PROD_BITS-2:15];
    t2    <= prod2[PROD_BITS-2:15];
    sidx2 <= sidx1;

    sum3  <= sum_c;
    t1_3  <= t1;
    t2_3  <= t2;
    sidx3 <= sidx2;
    if (sum_c > ONE_T) begin
      t0  <= '0;
      ov3 <= 1'b1;
    end else begin
      t0  <= rest_c[TIME_BITS:1];
      ov3 <= 1'b0;
    end

    result.sector        <= sidx3 + 3'd1;
    result.a_edge        <= edge_s[0];
    result.a_width       <= width_s[0];
    result.b_edge        <= edge_s[1];
    result.b_width       <= width_s[1];
    result.c_edge        <= edge_s[2];
    result.c_width       <= width_s[2];
    result.overmodulated <= ov3;
  end

endmodule
`default_nettype wire

// File: hw/rtl/space_vector_pwm_timing.sv
// An accepted word passes the front end register, the queue and the back end to done.
// Throughput: one word per cycle; the back end pipeline never stalls.
// The back end reads the two-port sine ROM at two mirrored addresses per word.
// Reset is synchronous; it empties the queue and clears every valid bit.
// The receiver cannot stall, so each result is shown for one cycle only.
`timescale 1ns / 1ps
`default_nettype none
module space_vector_pwm_timing
  import svpt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire cmd_word_t cmd,
  output logic           done,
  output result_word_t   result
);

  logic       accept;
  logic       sect_valid;
  sect_word_t sect;
  logic       q_not_empty;
  logic [1:0] q_count;
  sect_word_t q_head;

  assign busy   = (q_count == 2'd2);
  assign accept = start && !busy;

  svpt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (cmd),
    .sect_valid (sect_valid),
    .sect       (sect)
  );

  svpt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (sect_valid),
    .push_word (sect),
    .pop       (1'b1),
    .not_empty (q_not_empty),
    .count     (q_count),
    .head      (q_head)
  );

  svpt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_not_empty),
    .in_word  (q_head),
    .done     (done),
    .result   (result)
  );

endmodule
`default_nettype wire
